FILE: src/vgu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_pkg
// Shared widths, command codes, stage payloads and saturation helpers of the
// three-component vector unit.
// ---------------------------------------------------------------------------
package vgu_pkg;

  localparam int DW       = 32;            // data field width
  localparam int FB       = 16;            // fraction bits
  localparam int PW       = 2 * DW;        // product width
  localparam int SW       = PW + 2;        // sum of three products
  localparam int RW       = DW;            // square root width
  localparam int QW       = DW + FB;       // quotient width
  localparam int SQ_STEPS = RW;            // one root bit per stage
  localparam int DV_STEPS = QW;            // one quotient bit per stage
  localparam int LAT      = 2 + SQ_STEPS + DV_STEPS + 1;

  typedef enum logic [2:0] {
    CMD_DOT   = 3'd0,
    CMD_CROSS = 3'd1,
    CMD_SQLEN = 3'd2,
    CMD_LEN   = 3'd3,
    CMD_NORM  = 3'd4,
    CMD_DIV   = 3'd5
  } cmd_t;

  // payload carried alongside the square root pipeline
  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [DW-1:0]      ex;
    logic signed [DW-1:0]      ey;
    logic signed [DW-1:0]      ez;
    logic signed [DW-1:0]      es;
    logic [2:0]                neg;
    logic [2:0][DW-1:0]        amag;
    logic [DW-1:0]             dmag;
  } sq_side_t;

  // payload carried alongside the divider lanes
  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [DW-1:0]      ex;
    logic signed [DW-1:0]      ey;
    logic signed [DW-1:0]      ez;
    logic signed [DW-1:0]      es;
    logic [2:0]                neg;
    logic [RW-1:0]             root;
    logic                      dz;
  } dv_side_t;

  localparam int SQ_SIDE_W = $bits(sq_side_t);
  localparam int DV_SIDE_W = $bits(dv_side_t);

  // floor-shift a wide signed sum by FB and clamp to DW bits
  function automatic logic signed [DW-1:0] sat_shift(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    sh = v >>> FB;
    hi = SW'({1'b0, {(DW-1){1'b1}}});
    lo = -hi - SW'(1);
    if (sh > hi) begin
      sat_shift = {1'b0, {(DW-1){1'b1}}};
    end else if (sh < lo) begin
      sat_shift = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_shift = sh[DW-1:0];
    end
  endfunction

  // apply sign to an unsigned quotient and clamp to DW bits
  function automatic logic signed [DW-1:0] sat_quot(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] lim;
    lim = QW'({1'b1, {(DW-1){1'b0}}});
    if (neg) begin
      if (q > lim) sat_quot = {1'b1, {(DW-1){1'b0}}};
      else         sat_quot = -q[DW-1:0];
    end else begin
      if (q >= lim) sat_quot = {1'b0, {(DW-1){1'b1}}};
      else          sat_quot = q[DW-1:0];
    end
  endfunction

endpackage

FILE: src/vec3_geometry_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vec3_geometry_unit
// Q16.16 three-component vector unit: dot, cross, squared length, length,
// normalize and divide by scalar, with saturation and a divide fault flag.
//
//   channel | ports             | direction
//   --------+-------------------+----------
//   input   | in_valid/in_ready | in: command, vectors a and b, divisor
//   result  | out_valid/out_ready | out: r_x, r_y, r_z, r_scalar, fault
//
// One item per cycle while out_ready does not hold the pipeline; an item passes
// through two multiply/merge stages, a 32-stage square root and a 48-stage
// divider (one bit per stage), then the output register, 83 registers in all,
// and can be taken once it sits in the output register.
// Reset clears only the valid chain. The whole pipeline holds while a
// result waits and out_ready is low; in_ready is low only then.
// ---------------------------------------------------------------------------
module vec3_geometry_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic signed [vgu_pkg::DW-1:0] in_a_x,
  input  logic signed [vgu_pkg::DW-1:0] in_a_y,
  input  logic signed [vgu_pkg::DW-1:0] in_a_z,
  input  logic signed [vgu_pkg::DW-1:0] in_b_x,
  input  logic signed [vgu_pkg::DW-1:0] in_b_y,
  input  logic signed [vgu_pkg::DW-1:0] in_b_z,
  input  logic signed [vgu_pkg::DW-1:0] in_divisor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [vgu_pkg::DW-1:0] out_r_x,
  output logic signed [vgu_pkg::DW-1:0] out_r_y,
  output logic signed [vgu_pkg::DW-1:0] out_r_z,
  output logic signed [vgu_pkg::DW-1:0] out_r_scalar,
  output logic                          out_fault
);
  import vgu_pkg::*;

  logic               adv;
  logic [LAT-1:0]     v_r, v_nxt;

  // stage 1 side registers
  logic [2:0]         cmd1_r;
  logic [2:0]         neg1_r;
  logic [2:0][DW-1:0] amag1_r;
  logic [DW-1:0]      dmag1_r;
  logic signed [PW-1:0] pd [3];
  logic signed [PW-1:0] p1 [3];
  logic signed [PW-1:0] p2 [3];
  logic               sq;
  logic signed [DW-1:0] av [3];
  logic [2:0]         neg_in;
  logic [2:0][DW-1:0] amag_in;
  logic               dneg;

  // stage 2 merge registers
  logic [2:0]         cmd2_r;
  logic [2:0]         neg2_r;
  logic [2:0][DW-1:0] amag2_r;
  logic [DW-1:0]      dmag2_r;
  logic signed [SW-1:0] sum2_r;
  logic signed [SW-1:0] cr2_r [3];

  sq_side_t           sq_in, sq_out;
  logic [RW-1:0]      root;
  dv_side_t           dv_in, dv_out;
  logic [DW-1:0]      den;
  logic [2:0][QW-1:0] quot;

  logic signed [DW-1:0] rx_nxt, ry_nxt, rz_nxt, rs_nxt;
  logic                 flt_nxt;
  logic signed [DW-1:0] rx_r, ry_r, rz_r, rs_r;
  logic                 flt_r;

  assign adv      = !v_r[LAT-1] || out_ready;
  assign in_ready = adv;

  assign v_nxt = {v_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  // ---- stage 1: component lanes --------------------------------------------
  assign sq    = (in_command == CMD_SQLEN) || (in_command == CMD_LEN) ||
                 (in_command == CMD_NORM);
  assign av[0] = in_a_x;
  assign av[1] = in_a_y;
  assign av[2] = in_a_z;
  assign dneg  = in_divisor[DW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag_in[i] = av[i][DW-1] ? -av[i] : av[i];
      neg_in[i]  = (in_command == CMD_DIV) ? (av[i][DW-1] ^ dneg) : av[i][DW-1];
    end
  end

  vgu_lane u_lane_x (
    .clk(clk), .en(adv), .sq(sq), .ai(in_a_x), .bi(in_b_x),
    .aj(in_a_y), .bk(in_b_z), .ak(in_a_z), .bj(in_b_y),
    .p_dot_r(pd[0]), .p_c1_r(p1[0]), .p_c2_r(p2[0])
  );

  vgu_lane u_lane_y (
    .clk(clk), .en(adv), .sq(sq), .ai(in_a_y), .bi(in_b_y),
    .aj(in_a_z), .bk(in_b_x), .ak(in_a_x), .bj(in_b_z),
    .p_dot_r(pd[1]), .p_c1_r(p1[1]), .p_c2_r(p2[1])
  );

  vgu_lane u_lane_z (
    .clk(clk), .en(adv), .sq(sq), .ai(in_a_z), .bi(in_b_z),
    .aj(in_a_x), .bk(in_b_y), .ak(in_a_y), .bj(in_b_x),
    .p_dot_r(pd[2]), .p_c1_r(p1[2]), .p_c2_r(p2[2])
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= in_command;
      neg1_r  <= neg_in;
      amag1_r <= amag_in;
      dmag1_r <= dneg ? -in_divisor : in_divisor;
    end
  end

  // ---- stage 2: merge lane products -------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r  <= cmd1_r;
      neg2_r  <= neg1_r;
      amag2_r <= amag1_r;
      dmag2_r <= dmag1_r;
      sum2_r  <= SW'(pd[0]) + SW'(pd[1]) + SW'(pd[2]);
      for (int i = 0; i < 3; i++) begin
        cr2_r[i] <= SW'(p1[i]) - SW'(p2[i]);
      end
    end
  end

  // dot, squared length and cross results are final here; hold them alongside the root
  always_comb begin
    sq_in      = '0;
    sq_in.cmd  = cmd2_r;
    sq_in.neg  = neg2_r;
    sq_in.amag = amag2_r;
    sq_in.dmag = dmag2_r;
    if (cmd2_r == CMD_CROSS) begin
      sq_in.ex = sat_shift(cr2_r[0]);
      sq_in.ey = sat_shift(cr2_r[1]);
      sq_in.ez = sat_shift(cr2_r[2]);
    end
    if ((cmd2_r == CMD_DOT) || (cmd2_r == CMD_SQLEN)) begin
      sq_in.es = sat_shift(sum2_r);
    end
  end

  vgu_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
    .clk(clk), .en(adv), .n(sum2_r[PW-1:0]), .side(sq_in),
    .root(root), .side_out(sq_out)
  );

  // ---- divider ----------------------------------------------------------------
  assign den = (sq_out.cmd == CMD_DIV) ? sq_out.dmag : root;

  always_comb begin
    dv_in      = '0;
    dv_in.cmd  = sq_out.cmd;
    dv_in.ex   = sq_out.ex;
    dv_in.ey   = sq_out.ey;
    dv_in.ez   = sq_out.ez;
    dv_in.es   = sq_out.es;
    dv_in.neg  = sq_out.neg;
    dv_in.root = root;
    dv_in.dz   = (den == '0);
  end

  vgu_div #(.SIDE_W(DV_SIDE_W)) u_div (
    .clk(clk), .en(adv), .den(den), .num(sq_out.amag), .side(dv_in),
    .quot(quot), .side_out(dv_out)
  );

  // ---- result select ----------------------------------------------------------
  always_comb begin
    rx_nxt  = '0;
    ry_nxt  = '0;
    rz_nxt  = '0;
    rs_nxt  = '0;
    flt_nxt = 1'b0;
    case (dv_out.cmd)
      CMD_DOT, CMD_SQLEN: begin
        rs_nxt = dv_out.es;
      end
      CMD_CROSS: begin
        rx_nxt = dv_out.ex;
        ry_nxt = dv_out.ey;
        rz_nxt = dv_out.ez;
      end
      CMD_LEN: begin
        rs_nxt = dv_out.root[RW-1] ? {1'b0, {(DW-1){1'b1}}} : DW'(dv_out.root);
      end
      CMD_NORM, CMD_DIV: begin
        if (dv_out.dz) begin
          flt_nxt = 1'b1;
        end else begin
          rx_nxt = sat_quot(quot[0], dv_out.neg[0]);
          ry_nxt = sat_quot(quot[1], dv_out.neg[1]);
          rz_nxt = sat_quot(quot[2], dv_out.neg[2]);
        end
      end
      default: begin
        flt_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      rz_r  <= rz_nxt;
      rs_r  <= rs_nxt;
      flt_r <= flt_nxt;
    end
  end

  assign out_valid    = v_r[LAT-1];
  assign out_r_x      = rx_r;
  assign out_r_y      = ry_r;
  assign out_r_z      = rz_r;
  assign out_r_scalar = rs_r;
  assign out_fault    = flt_r;

endmodule

FILE: src/vgu_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_lane
// One component lane: the component square or dot term and the two cross
// product terms, each from its own registered multiplier.
// ---------------------------------------------------------------------------
module vgu_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              sq,
  input  logic signed [vgu_pkg::DW-1:0]     ai,
  input  logic signed [vgu_pkg::DW-1:0]     bi,
  input  logic signed [vgu_pkg::DW-1:0]     aj,
  input  logic signed [vgu_pkg::DW-1:0]     bk,
  input  logic signed [vgu_pkg::DW-1:0]     ak,
  input  logic signed [vgu_pkg::DW-1:0]     bj,
  output logic signed [vgu_pkg::PW-1:0]     p_dot_r,
  output logic signed [vgu_pkg::PW-1:0]     p_c1_r,
  output logic signed [vgu_pkg::PW-1:0]     p_c2_r
);
  import vgu_pkg::*;

  logic signed [DW-1:0] mop;

  assign mop = sq ? ai : bi;

  always_ff @(posedge clk) begin
    if (en) begin
      p_dot_r <= PW'(ai) * PW'(mop);
      p_c1_r  <= PW'(aj) * PW'(bk);
      p_c2_r  <= PW'(ak) * PW'(bj);
    end
  end

endmodule

FILE: src/vgu_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_isqrt
// Pipelined integer square root, one root bit per stage, with a side
// payload that travels in step.
// ---------------------------------------------------------------------------
module vgu_isqrt #(
  parameter int SIDE_W = vgu_pkg::SQ_SIDE_W
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [vgu_pkg::PW-1:0]    n,
  input  logic [SIDE_W-1:0]         side,
  output logic [vgu_pkg::RW-1:0]    root,
  output logic [SIDE_W-1:0]         side_out
);
  import vgu_pkg::*;

  logic [PW-1:0]     n_r    [SQ_STEPS];
  logic [RW+1:0]     rem_r  [SQ_STEPS];
  logic [RW-1:0]     root_r [SQ_STEPS];
  logic [SIDE_W-1:0] side_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    localparam int PB = 2 * (SQ_STEPS - 1 - k);
    logic [PW-1:0]     n_in;
    logic [RW+1:0]     rem_in;
    logic [RW-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;

    if (k == 0) begin : g_first
      assign n_in    = n;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side;
    end else begin : g_next
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rem_sh = {rem_in[RW-1:0], n_in[PB+1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_in;
        side_r[k] <= side_in;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root     = root_r[SQ_STEPS-1];
  assign side_out = side_r[SQ_STEPS-1];

endmodule

FILE: src/vgu_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_div
// Three restoring divider lanes sharing one divisor, one quotient bit per
// stage; each numerator is scaled by the fraction width.
// ---------------------------------------------------------------------------
module vgu_div #(
  parameter int SIDE_W = vgu_pkg::DV_SIDE_W
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [vgu_pkg::DW-1:0]           den,
  input  logic [2:0][vgu_pkg::DW-1:0]      num,
  input  logic [SIDE_W-1:0]                side,
  output logic [2:0][vgu_pkg::QW-1:0]      quot,
  output logic [SIDE_W-1:0]                side_out
);
  import vgu_pkg::*;

  logic [DW-1:0]         den_r  [DV_STEPS];
  logic [2:0][QW-1:0]    num_r  [DV_STEPS];
  logic [2:0][DW-1:0]    rem_r  [DV_STEPS];
  logic [2:0][QW-1:0]    q_r    [DV_STEPS];
  logic [SIDE_W-1:0]     side_r [DV_STEPS];

  for (genvar k = 0; k < DV_STEPS; k++) begin : g_stage
    localparam int NB = DV_STEPS - 1 - k;
    logic [DW-1:0]      den_in;
    logic [2:0][QW-1:0] num_in;
    logic [2:0][DW-1:0] rem_in;
    logic [2:0][QW-1:0] q_in;
    logic [SIDE_W-1:0]  side_in;

    if (k == 0) begin : g_first
      assign den_in  = den;
      assign num_in  = {{num[2], {FB{1'b0}}}, {num[1], {FB{1'b0}}}, {num[0], {FB{1'b0}}}};
      assign rem_in  = '0;
      assign q_in    = '0;
      assign side_in = side;
    end else begin : g_next
      assign den_in  = den_r[k-1];
      assign num_in  = num_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_in;
        num_r[k]  <= num_in;
        side_r[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [DW:0] sh;
      assign sh = {rem_in[l], num_in[l][NB]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (sh >= {1'b0, den_in}) begin
            rem_r[k][l] <= DW'(sh - {1'b0, den_in});
            q_r[k][l]   <= {q_in[l][QW-2:0], 1'b1};
          end else begin
            rem_r[k][l] <= sh[DW-1:0];
            q_r[k][l]   <= {q_in[l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign quot     = q_r[DV_STEPS-1];
  assign side_out = side_r[DV_STEPS-1];

endmodule

FILE: tb/sv/vgu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgu_checker
// Watches both channels of the vector unit. Computes the expected result of
// every accepted item and compares each delivered result in order.
// ---------------------------------------------------------------------------
module vgu_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic signed [vgu_pkg::DW-1:0] in_a_x,
  input  logic signed [vgu_pkg::DW-1:0] in_a_y,
  input  logic signed [vgu_pkg::DW-1:0] in_a_z,
  input  logic signed [vgu_pkg::DW-1:0] in_b_x,
  input  logic signed [vgu_pkg::DW-1:0] in_b_y,
  input  logic signed [vgu_pkg::DW-1:0] in_b_z,
  input  logic signed [vgu_pkg::DW-1:0] in_divisor,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [vgu_pkg::DW-1:0] out_r_x,
  input  logic signed [vgu_pkg::DW-1:0] out_r_y,
  input  logic signed [vgu_pkg::DW-1:0] out_r_z,
  input  logic signed [vgu_pkg::DW-1:0] out_r_scalar,
  input  logic                          out_fault,
  output int                            n_errors,
  output int                            n_pending,
  output int                            n_results
);
  import vgu_pkg::*;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] rs;
    logic               fault;
  } vec_result_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  vec_result_t result_q[$];

  // floor-shift an exact sum of products and clamp
  function automatic logic signed [31:0] clamp_floor(input logic signed [127:0] s);
    logic signed [127:0] sh;
    sh = s >>> FB;
    if (sh > 128'sd2147483647) return S32_MAX;
    if (sh < -128'sd2147483648) return S32_MIN;
    return sh[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? 64'(-w) : 64'(w);
  endfunction

  // value * 2^FB / den magnitude, truncated toward zero, then clamped
  function automatic logic signed [31:0] frac_quot(input logic signed [31:0] v,
                                                   input logic [63:0] den, input logic neg);
    logic [63:0] q;
    q = (magnitude(v) << FB) / den;
    if (neg) begin
      if (q > 64'h80000000) return S32_MIN;
      return -q[31:0];
    end
    if (q >= 64'h80000000) return S32_MAX;
    return q[31:0];
  endfunction

  function automatic vec_result_t predict_vec(input logic [2:0] cmd,
      input logic signed [127:0] ax, input logic signed [127:0] ay,
      input logic signed [127:0] az, input logic signed [127:0] bx,
      input logic signed [127:0] by, input logic signed [127:0] bz,
      input logic signed [31:0] dv);
    vec_result_t r;
    logic [63:0] ssq;
    logic [63:0] len;
    logic [63:0] dm;
    r = '{0, 0, 0, 0, 1'b0};
    case (cmd)
      CMD_DOT:   r.rs = clamp_floor(ax * bx + ay * by + az * bz);
      CMD_CROSS: begin
        r.rx = clamp_floor(ay * bz - az * by);
        r.ry = clamp_floor(az * bx - ax * bz);
        r.rz = clamp_floor(ax * by - ay * bx);
      end
      CMD_SQLEN: r.rs = clamp_floor(ax * ax + ay * ay + az * az);
      CMD_LEN, CMD_NORM: begin
        ssq = 64'(ax * ax + ay * ay + az * az);
        len = int_sqrt(ssq);
        if (cmd == CMD_LEN) begin
          r.rs = (len > 64'h7fffffff) ? S32_MAX : len[31:0];
        end else if (len == 0) begin
          r.fault = 1'b1;
        end else begin
          r.rx = frac_quot(ax[31:0], len, ax < 0);
          r.ry = frac_quot(ay[31:0], len, ay < 0);
          r.rz = frac_quot(az[31:0], len, az < 0);
        end
      end
      CMD_DIV: begin
        if (dv == 0) begin
          r.fault = 1'b1;
        end else begin
          dm = magnitude(dv);
          r.rx = frac_quot(ax[31:0], dm, (ax < 0) != (dv < 0));
          r.ry = frac_quot(ay[31:0], dm, (ay < 0) != (dv < 0));
          r.rz = frac_quot(az[31:0], dm, (az < 0) != (dv < 0));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  initial begin
    n_errors = 0;
    n_pending = 0;
    n_results = 0;
  end

  always @(posedge clk) begin
    vec_result_t w;
    if (rst_n) begin
      if (in_valid && in_ready)
        result_q.push_back(predict_vec(in_command, in_a_x, in_a_y, in_a_z,
                                       in_b_x, in_b_y, in_b_z, in_divisor));
      if (out_valid && out_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          w = result_q.pop_front();
          if (out_r_x !== w.rx) report_mismatch("r_x", out_r_x, w.rx);
          if (out_r_y !== w.ry) report_mismatch("r_y", out_r_y, w.ry);
          if (out_r_z !== w.rz) report_mismatch("r_z", out_r_z, w.rz);
          if (out_r_scalar !== w.rs) report_mismatch("r_scalar", out_r_scalar, w.rs);
          if (out_fault !== w.fault) report_mismatch("fault", out_fault, w.fault);
        end
      end
      n_pending = result_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random vector commands into the vector unit under
// varying idle and stall patterns; the checker compares every result.
// ---------------------------------------------------------------------------
module tb_top;
  import vgu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_command;
  logic signed [DW-1:0] in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z, in_divisor;
  logic        out_valid;
  logic        out_ready;
  logic signed [DW-1:0] out_r_x, out_r_y, out_r_z, out_r_scalar;
  logic        out_fault;
  int          n_errors, n_pending, n_results;
  int          idle_pct, stall_pct;
  logic        hold_req;
  int          cycle_cnt;
  int          n_sent;

  vec3_geometry_unit u_dut (.*);

  vgu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    logic held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
      2: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] ax,
      input logic signed [31:0] ay, input logic signed [31:0] az,
      input logic signed [31:0] bx, input logic signed [31:0] by,
      input logic signed [31:0] bz, input logic signed [31:0] dv);
    @(negedge clk);
    in_command = cmd;
    in_a_x = ax; in_a_y = ay; in_a_z = az;
    in_b_x = bx; in_b_y = by; in_b_z = bz;
    in_divisor = dv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    // insert idle cycles between items
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic send_random();
    logic [2:0] cmd;
    logic signed [31:0] dv;
    cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                       : 3'($urandom_range(0, 5));
    dv = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_val();
    if (cmd == CMD_NORM && $urandom_range(0, 9) == 0)
      send_item(cmd, 0, 0, 0, rand_val(), rand_val(), rand_val(), dv);
    else
      send_item(cmd, rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
                rand_val(), dv);
  endtask

  initial begin
    cycle_cnt = 0;
    n_sent = 0;
    hold_req = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_DOT;
    in_a_x = 0; in_a_y = 0; in_a_z = 0;
    in_b_x = 0; in_b_y = 0; in_b_z = 0;
    in_divisor = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes, every command, zero vector, divide by zero, unknown codes
    send_item(CMD_DOT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
    send_item(CMD_DOT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
    send_item(CMD_DOT, 32'sh00010000, 32'sh00020000, -32'sh00030000,
              32'sh00010000, -32'sh00008000, 32'sh00010000, 0);
    send_item(CMD_CROSS, 32'sh00010000, 0, 0, 0, 32'sh00010000, 0, 0);
    send_item(CMD_CROSS, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
    send_item(CMD_SQLEN, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    send_item(CMD_SQLEN, -1, -1, -1, 0, 0, 0, 0);
    send_item(CMD_LEN, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    send_item(CMD_LEN, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0);
    send_item(CMD_LEN, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_NORM, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_NORM, 32'sh00030000, -32'sh00040000, 0, 0, 0, 0, 0);
    send_item(CMD_NORM, 1, 0, 0, 0, 0, 0, 0);
    send_item(CMD_NORM, 32'sh80000000, 0, 0, 0, 0, 0, 0);
    send_item(CMD_NORM, 32'sh7fffffff, 32'sh80000000, 1, 0, 0, 0, 0);
    send_item(CMD_DIV, 32'sh00010000, 2, 3, 0, 0, 0, 0);
    send_item(CMD_DIV, 32'sh80000000, 32'sh7fffffff, -1, 0, 0, 0, -1);
    send_item(CMD_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh00050000, 0, 0, 0, 1);
    send_item(CMD_DIV, 32'sh00060000, -32'sh00060000, 7, 0, 0, 0, 32'sh80000000);
    send_item(CMD_DIV, 32'sh00060000, -32'sh00060000, 7, 0, 0, 0, 32'sh00020000);
    send_item(3'd6, 5, 6, 7, 8, 9, 10, 11);
    send_item(3'd7, -1, -1, -1, -1, -1, -1, 0);

    // idle/stall phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 36 : 0;
      stall_pct = (ph == 2) ? 48 : (ph == 3) ? 36 : 0;
      repeat (140) send_random();
    end

    // pause the sender until the pipeline drains
    @(negedge clk);
    in_valid = 1'b0;
    while (n_pending != 0) @(posedge clk);

    // long receiver hold-off while items keep coming
    idle_pct = 0;
    stall_pct = 20;
    hold_req = 1'b1;
    repeat (70) send_random();

    @(negedge clk);
    in_valid = 1'b0;
    while (n_pending != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);

    $display("sent %0d items, checked %0d results across all six commands,",
             n_sent, n_results);
    $display("idle/stall phases, a long output hold-off and unknown codes");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
